>>> rtl/epr_pkg.sv
// Shared types and constants for the emulation prevention byte remover.
// Used by epr_decode, epr_emit and emulation_prevention_remover_unit.
package epr_pkg;

    localparam logic [7:0] EPB_BYTE = 8'h03;

    localparam logic [1:0] ESC_IDLE     = 2'd0;
    localparam logic [1:0] ESC_ONE_ZERO = 2'd1;
    localparam logic [1:0] ESC_TWO_ZERO = 2'd2;
    localparam logic [1:0] ESC_DROPPED  = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       unit_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       run_last;
        logic       unit_end;
    } out_item_t;

    typedef struct packed {
        logic      two;
        out_item_t first;
        out_item_t second;
    } result_pair_t;

endpackage

>>> rtl/epr_decode.sv
// Input register, escape state and per-byte decode of the result pair.
// Depends on epr_pkg.
module epr_decode
    import epr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  in_item_t     in_data,
    output logic         pair_valid,
    input  logic         pair_take,
    output result_pair_t pair
);

    logic       item_valid_reg;
    in_item_t   item_reg;
    logic [1:0] esc_reg;
    logic [1:0] esc_next;
    logic [1:0] zero_next;
    logic [7:0] b;
    logic       last;

    assign in_ready   = !item_valid_reg || pair_take;
    assign pair_valid = item_valid_reg;
    assign b          = item_reg.in_byte;
    assign last       = item_reg.unit_last;

    always_comb
    begin
        pair.two    = 1'b0;
        pair.first  = '{out_byte: b, out_valid: 1'b1, run_last: 1'b1, unit_end: last};
        pair.second = '{out_byte: b, out_valid: 1'b1, run_last: 1'b1, unit_end: last};
        zero_next   = ESC_IDLE;
        esc_next    = ESC_IDLE;
        priority if (esc_reg == ESC_TWO_ZERO && b == EPB_BYTE)
        begin
            pair.first = '{out_byte: 8'h00, out_valid: 1'b0, run_last: 1'b1, unit_end: last};
            esc_next   = last ? ESC_IDLE : ESC_DROPPED;
        end
        else
        begin
            if (b == 8'h00)
            begin
                unique case (esc_reg)
                    ESC_IDLE:     zero_next = ESC_ONE_ZERO;
                    ESC_ONE_ZERO: zero_next = ESC_TWO_ZERO;
                    ESC_TWO_ZERO: zero_next = ESC_IDLE;
                    ESC_DROPPED:  zero_next = ESC_ONE_ZERO;
                    default:      zero_next = ESC_IDLE;
                endcase
            end
            if (esc_reg == ESC_DROPPED && b > EPB_BYTE)
            begin
                pair.two   = 1'b1;
                pair.first = '{out_byte: EPB_BYTE, out_valid: 1'b1, run_last: 1'b0,
                               unit_end: 1'b0};
            end
            esc_next = last ? ESC_IDLE : zero_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            esc_reg        <= ESC_IDLE;
        end
        else
        begin
            if (pair_take)
            begin
                esc_reg <= esc_next;
            end
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_data;
        end
    end

endmodule

>>> rtl/epr_emit.sv
// Result register with one extra slot for the second result of a reinserted escape.
// Depends on epr_pkg.
module epr_emit
    import epr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pair_valid,
    output logic         pair_take,
    input  result_pair_t pair,
    output logic         out_valid,
    input  logic         out_ready,
    output out_item_t    out_data
);

    logic      head_valid_reg;
    out_item_t head_reg;
    logic      tail_valid_reg;
    out_item_t tail_reg;
    logic      head_free;

    assign head_free = !head_valid_reg || out_ready;
    assign pair_take = pair_valid && head_free && !tail_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else if (head_free)
        begin
            if (tail_valid_reg)
            begin
                head_valid_reg <= 1'b1;
                tail_valid_reg <= 1'b0;
            end
            else
            begin
                head_valid_reg <= pair_valid;
                tail_valid_reg <= pair_valid && pair.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_free)
        begin
            if (tail_valid_reg)
            begin
                head_reg <= tail_reg;
            end
            else if (pair_valid)
            begin
                head_reg <= pair.first;
                tail_reg <= pair.second;
            end
        end
    end

endmodule

>>> rtl/emulation_prevention_remover_unit.sv
// Top level of the emulation prevention byte remover.
// Depends on epr_pkg, epr_decode and epr_emit.
//
// The unit takes one escaped byte per transaction and returns one result per byte, or
// two when a dropped 0x03 has to be put back in; it sustains one byte per cycle while
// out_ready stays high, and a byte that gives two results holds the input while the
// result register drains its second slot. Bytes pass the input and result registers.
module emulation_prevention_remover_unit
    import epr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic         pair_valid;
    logic         pair_take;
    result_pair_t pair;

    epr_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .pair_valid (pair_valid),
        .pair_take  (pair_take),
        .pair       (pair)
    );

    epr_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_take  (pair_take),
        .pair       (pair),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
